// ----- rtl/pss_pkg.sv -----
`default_nettype none
package pss_pkg;

  // fixed field widths
  localparam int unsigned SINCE_W   = 28;
  localparam int unsigned IVL_W     = 20;
  localparam int unsigned BUF_W     = 2;
  localparam int unsigned SLICE_N_W = 8;

  // reset values
  localparam logic [IVL_W-1:0]   MAX_INTERVAL_RESET = IVL_W'(1000000);
  localparam logic [SINCE_W-1:0] SINCE_MAX          = '1;
  localparam logic [BUF_W-1:0]   DRAW_BUF_RESET     = BUF_W'(0);
  localparam logic [BUF_W-1:0]   QUEUE_BUF_RESET    = BUF_W'(0);
  localparam logic [BUF_W-1:0]   FILL_BUF_RESET     = BUF_W'(1);

  // per-tick events from the slice timing to the buffer control
  typedef struct packed {
    logic strobe;
    logic reload;
  } tick_evt_t;

  // buffer that is neither drawn nor queued
  function automatic logic [BUF_W-1:0] pick_free(input logic [BUF_W-1:0] drawn,
                                                 input logic [BUF_W-1:0] queued);
    logic [BUF_W-1:0] res;
    if (drawn == BUF_W'(0) || queued == BUF_W'(0)) begin
      if (drawn == BUF_W'(1) || queued == BUF_W'(1)) begin
        res = BUF_W'(2);
      end else begin
        res = BUF_W'(1);
      end
    end else begin
      res = BUF_W'(0);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pss_in_if.sv -----
`default_nettype none
interface pss_in_if;
  logic valid;
  logic ready;
  logic sensor_edge;
  logic fill_start;
  logic fill_done;

  modport source (output valid, output sensor_edge, output fill_start, output fill_done,
                  input ready);
  modport sink (input valid, input sensor_edge, input fill_start, input fill_done,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/pss_out_if.sv -----
`default_nettype none
interface pss_out_if;
  import pss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SLICE_N_W-1:0] slice_number;
  logic                 draw_strobe;
  logic [BUF_W-1:0]     draw_buffer;
  logic [BUF_W-1:0]     fill_buffer;
  logic [IVL_W-1:0]     slice_interval;

  modport source (output valid, output slice_number, output draw_strobe,
                  output draw_buffer, output fill_buffer, output slice_interval,
                  input ready);
  modport sink (input valid, input slice_number, input draw_strobe,
                input draw_buffer, input fill_buffer, input slice_interval,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/pss_cfg_if.sv -----
`default_nettype none
interface pss_cfg_if;
  import pss_pkg::*;
  logic             valid;
  logic             ready;
  logic [IVL_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/pss_timing.sv -----
`default_nettype none
module pss_timing #(
  parameter int unsigned SLICES = 224
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          sensor_edge,
  input  wire logic [pss_pkg::IVL_W-1:0]     max_interval,
  output logic      [pss_pkg::SLICE_N_W-1:0] slice_next,
  output logic      [pss_pkg::IVL_W-1:0]     interval_next,
  output pss_pkg::tick_evt_t                 evt
);
  import pss_pkg::*;

  localparam int unsigned SW = (SLICES > 1) ? $clog2(SLICES) : 1;
  localparam int unsigned QW = SINCE_W - SW + 1;
  localparam int unsigned CW = (QW > IVL_W) ? QW : IVL_W;
  localparam logic [SW-1:0] LAST = SW'(SLICES - 1);

  logic [SINCE_W-1:0] since_edge;
  logic [QW-1:0]      since_q;
  logic [SW-1:0]      since_r;
  logic [IVL_W-1:0]   interval_reg;
  logic [IVL_W-1:0]   slice_timer;
  logic [SW-1:0]      slice_reg;

  logic [SINCE_W-1:0] since_edge_next;
  logic [QW-1:0]      since_q_next;
  logic [SW-1:0]      since_r_next;
  logic [IVL_W-1:0]   slice_timer_next;
  logic [SW-1:0]      slice_reg_next;
  logic [QW-1:0]      period_q;
  logic               sat;
  logic               r_last;
  logic [IVL_W-1:0]   timer_inc;
  logic [IVL_W-1:0]   eff;

  // since_edge kept alongside its quotient and remainder by the slice count
  always_comb begin
    sat    = (since_edge == SINCE_MAX);
    r_last = (since_r == LAST);
    period_q = sat ? since_q : since_q + QW'(r_last);
    if (sensor_edge) begin
      since_edge_next = '0;
      since_q_next    = '0;
      since_r_next    = '0;
    end else if (sat) begin
      since_edge_next = since_edge;
      since_q_next    = since_q;
      since_r_next    = since_r;
    end else begin
      since_edge_next = since_edge + SINCE_W'(1);
      since_q_next    = period_q;
      since_r_next    = r_last ? '0 : since_r + SW'(1);
    end
  end

  // interval update and slice stepping
  always_comb begin
    timer_inc        = slice_timer + IVL_W'(1);
    eff              = (interval_reg == '0) ? IVL_W'(1) : interval_reg;
    interval_next    = interval_reg;
    slice_timer_next = timer_inc;
    slice_reg_next   = slice_reg;
    evt              = '0;
    if (sensor_edge) begin
      if (CW'(period_q) > CW'(max_interval)) begin
        interval_next = max_interval;
      end else begin
        interval_next = IVL_W'(period_q);
      end
      slice_timer_next = '0;
      slice_reg_next   = '0;
      evt.strobe       = 1'b1;
      evt.reload       = 1'b1;
    end else if (timer_inc >= eff) begin
      slice_timer_next = '0;
      evt.strobe       = 1'b1;
      if (slice_reg == LAST) begin
        slice_reg_next = '0;
        evt.reload     = 1'b1;
      end else begin
        slice_reg_next = slice_reg + SW'(1);
      end
    end
    slice_next = SLICE_N_W'(slice_reg_next);
  end

  // timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      since_edge   <= '0;
      since_q      <= '0;
      since_r      <= '0;
      interval_reg <= MAX_INTERVAL_RESET;
      slice_timer  <= '0;
      slice_reg    <= '0;
    end else if (en) begin
      since_edge   <= since_edge_next;
      since_q      <= since_q_next;
      since_r      <= since_r_next;
      interval_reg <= interval_next;
      slice_timer  <= slice_timer_next;
      slice_reg    <= slice_reg_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pss_buffers.sv -----
`default_nettype none
module pss_buffers (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire pss_pkg::tick_evt_t        evt,
  input  wire logic                      fill_start,
  input  wire logic                      fill_done,
  output logic      [pss_pkg::BUF_W-1:0] draw_next,
  output logic      [pss_pkg::BUF_W-1:0] fill_next
);
  import pss_pkg::*;

  logic [BUF_W-1:0] drawing_buf;
  logic [BUF_W-1:0] queued_buf;
  logic [BUF_W-1:0] loading_buf;
  logic [BUF_W-1:0] queued_next;

  // reload first, then fill start, then fill done
  always_comb begin
    draw_next   = evt.reload ? queued_buf : drawing_buf;
    fill_next   = fill_start ? pick_free(draw_next, queued_buf) : loading_buf;
    queued_next = fill_done ? fill_next : queued_buf;
  end

  // triple-buffer indices
  always_ff @(posedge clk) begin
    if (rst) begin
      drawing_buf <= DRAW_BUF_RESET;
      queued_buf  <= QUEUE_BUF_RESET;
      loading_buf <= FILL_BUF_RESET;
    end else if (en) begin
      drawing_buf <= draw_next;
      queued_buf  <= queued_next;
      loading_buf <= fill_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pov_slice_scheduler.sv -----
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle while the result is taken, the state update is a single pass per tick
// input register and result register both stall only when the result is not taken
// rst is synchronous: timing, buffer indices and max_interval return to reset values
`default_nettype none
module pov_slice_scheduler #(
  parameter int unsigned SLICES = 224
) (
  input wire logic   clk,
  input wire logic   rst,
  pss_in_if.sink     in_ch,
  pss_out_if.source  out_ch,
  pss_cfg_if.sink    cfg
);
  import pss_pkg::*;

  logic               in_valid;
  logic               in_edge;
  logic               in_fstart;
  logic               in_fdone;
  logic               advance;
  logic [IVL_W-1:0]   max_interval;
  logic [SLICE_N_W-1:0] slice_next;
  logic [IVL_W-1:0]   interval_next;
  logic [BUF_W-1:0]   draw_next;
  logic [BUF_W-1:0]   fill_next;
  tick_evt_t          evt;

  // handshakes
  assign advance     = in_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;
  assign cfg.ready   = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_interval <= MAX_INTERVAL_RESET;
    end else if (cfg.valid) begin
      max_interval <= cfg.data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_edge   <= in_ch.sensor_edge;
      in_fstart <= in_ch.fill_start;
      in_fdone  <= in_ch.fill_done;
    end
  end

  pss_timing #(
    .SLICES (SLICES)
  ) u_timing (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .sensor_edge   (in_edge),
    .max_interval  (max_interval),
    .slice_next    (slice_next),
    .interval_next (interval_next),
    .evt           (evt)
  );

  pss_buffers u_buffers (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .evt        (evt),
    .fill_start (in_fstart),
    .fill_done  (in_fdone),
    .draw_next  (draw_next),
    .fill_next  (fill_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.slice_number   <= slice_next;
      out_ch.draw_strobe    <= evt.strobe;
      out_ch.draw_buffer    <= draw_next;
      out_ch.fill_buffer    <= fill_next;
      out_ch.slice_interval <= interval_next;
    end
  end

endmodule
`default_nettype wire
